>>> hw/rtl/bfca_pkg.sv
// ----------------------------------------------------------------------------
// bfca_pkg: shared types and constants of the bloom filter check/add block
// Holds default sizes, hash constants, result codes, the job descriptor
// that goes from front to back, and the back state encoding.
// ----------------------------------------------------------------------------
package bfca_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int DEF_MAX_FILTER_BITS = 65536;
   localparam int DEF_MAX_KEY_BYTES   = 64;
   localparam int DEF_MAX_HASHES      = 32;

   // Widest key length that the job descriptor carries (up to 2047 bytes).
   localparam int JOB_LEN_W = 11;

   // Hash constants.
   localparam logic [31:0] SEED0 = 32'h9747_b28c;
   localparam logic [31:0] MIX_M = 32'h5bd1_e995;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_NUM_BITS   = 8'd0;
   localparam logic [7:0] CSR_NUM_HASHES = 8'd1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ABSENT   = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_NOCONFIG = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   // What the back has to do with a finished key.
   typedef enum logic [1:0] {
      JOB_HASH     = 2'd0,
      JOB_NOCONFIG = 2'd1,
      JOB_TOO_LONG = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic                 add;
      job_kind_type         kind;
      logic [JOB_LEN_W-1:0] len;
   } job_type;

   // Status that the back shows the front.
   typedef struct packed {
      logic clearing;
      logic key_free;
   } back_stat_type;

   typedef enum logic [4:0] {
      B_CLEAR, B_IDLE, B_NEXT, B_RD, B_CAP,
      B_K1, B_K2, B_H1, B_H2, B_T1, B_T2, B_F1, B_F2,
      B_PDIV, B_PRD, B_PCHK, B_DONE
   } back_state_type;

endpackage

>>> hw/rtl/bfca_ram.sv
// ----------------------------------------------------------------------------
// bfca_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bfca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bfca_queue.sv
// ----------------------------------------------------------------------------
// bfca_queue: two-entry job queue between front and back
// Holds finished-key descriptors so that front and back stall on their own.
// ----------------------------------------------------------------------------
module bfca_queue
   import bfca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   input  logic    pop,
   output job_type dout,
   output logic    full,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);

endmodule

>>> hw/rtl/bfca_front.sv
// ----------------------------------------------------------------------------
// bfca_front: key byte intake
// Accepts key bytes, stores them in the key buffer, counts the length and
// flags overflow, and on the last byte queues a classified job.
// ----------------------------------------------------------------------------
module bfca_front
   import bfca_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tuser,
   input  logic [16:0]                      num_bits,
   input  back_stat_type                    bstat,
   input  logic                             q_full,
   output logic                             job_push,
   output job_type                          job,
   output logic                             buf_we,
   output logic [$clog2(MAX_KEY_BYTES)-1:0] buf_waddr,
   output logic [7:0]                       buf_wdata
);

   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int KA_W  = $clog2(MAX_KEY_BYTES);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             hold_ff, hold_in;
   logic             accept;
   logic             fits;
   logic [LEN_W-1:0] len_nx;
   logic             ovf_nx;

   // The buffer is held from a key's last byte until the back has hashed it.
   assign req_tready = !bstat.clearing && !hold_ff && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign fits       = (len_ff < LEN_W'(MAX_KEY_BYTES));
   assign len_nx     = fits ? len_ff + LEN_W'(1) : len_ff;
   assign ovf_nx     = ovf_ff || !fits;

   assign buf_we    = accept && fits;
   assign buf_waddr = len_ff[KA_W-1:0];
   assign buf_wdata = req_tdata;

   // Classify the finished key.
   always_comb begin
      job.add = req_tuser;
      job.len = JOB_LEN_W'(len_nx);
      if (num_bits == 17'd0) begin
         job.kind = JOB_NOCONFIG;
      end else if (ovf_nx) begin
         job.kind = JOB_TOO_LONG;
      end else begin
         job.kind = JOB_HASH;
      end
   end

   assign job_push = accept && req_tlast;

   // Length, overflow and buffer hold.
   always_comb begin
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      hold_in = hold_ff;
      if (bstat.key_free) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         if (req_tlast) begin
            len_in  = '0;
            ovf_in  = 1'b0;
            hold_in = 1'b1;
         end else begin
            len_in = len_nx;
            ovf_in = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         hold_ff <= hold_in;
      end
   end

endmodule

>>> hw/rtl/bfca_back.sv
// ----------------------------------------------------------------------------
// bfca_back: hashing and probing engine
// Clears the filter after reset, runs two MurmurHash2 passes over the key
// buffer with one shared multiplier, reduces each probe position with a
// bit-serial remainder unit, probes and sets filter bits, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module bfca_back
   import bfca_pkg::*;
#(
   parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
   parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
   parameter int MAX_HASHES      = DEF_MAX_HASHES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [16:0]                      num_bits,
   input  logic [5:0]                       num_hashes,
   input  logic                             q_empty,
   input  job_type                          q_dout,
   output logic                             q_pop,
   output back_stat_type                    bstat,
   output logic [$clog2(MAX_KEY_BYTES)-1:0] buf_raddr,
   input  logic [7:0]                       buf_rdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata
);

   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int KA_W  = $clog2(MAX_KEY_BYTES);
   localparam int NB_W  = $clog2(MAX_FILTER_BITS + 1);
   localparam int FA_W  = $clog2(MAX_FILTER_BITS);
   localparam int HC_W  = $clog2(MAX_HASHES + 1);

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [31:0]      h_ff, h_in, k_ff, k_in, p_ff, p_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in, x_ff, x_in, xs_ff, xs_in;
   logic             pass_ff, pass_in;
   logic [KA_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0] rest_ff, rest_in;
   logic [1:0]       bc_ff, bc_in;
   logic [2:0]       chunk_ff, chunk_in;
   logic [NB_W-1:0]  r_ff, r_in;
   logic [4:0]       bit_ff, bit_in;
   logic [HC_W-1:0]  pi_ff, pi_in;
   logic [5:0]       hits_ff, hits_in;
   logic [1:0]       status_ff, status_in;
   logic [FA_W-1:0]  clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_full;
   logic [31:0]      len32;
   logic [31:0]      hfin;
   logic [NB_W-1:0]  nb;
   logic [HC_W-1:0]  nh;
   logic [NB_W:0]    rem_t;
   logic [5:0]       hits_nx;
   logic [31:0]      x_nx;
   logic             fil_we;
   logic [FA_W-1:0]  fil_waddr;
   logic             fil_wdata;
   logic             fil_rdata;

   // Saturated filter size and probe count.
   always_comb begin
      if (32'(num_bits) > 32'(MAX_FILTER_BITS)) begin
         nb = NB_W'(MAX_FILTER_BITS);
      end else begin
         nb = NB_W'(num_bits);
      end
      if (32'(num_hashes) > 32'(MAX_HASHES)) begin
         nh = HC_W'(MAX_HASHES);
      end else begin
         nh = HC_W'(num_hashes);
      end
   end

   // Shared 32-bit multiplier, low half only, result registered in p_ff.
   assign mul_full = mul_a * mul_b;
   assign len32    = 32'(job_ff.len);
   assign hfin     = p_ff ^ (p_ff >> 15);
   assign rem_t    = {r_ff, xs_ff[31]};
   assign x_nx     = x_ff + b_ff;
   assign hits_nx  = fil_rdata ? hits_ff + 6'd1 : hits_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      xs_in        = xs_ff;
      pass_in      = pass_ff;
      pos_in       = pos_ff;
      rest_in      = rest_ff;
      bc_in        = bc_ff;
      chunk_in     = chunk_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      pi_in        = pi_ff;
      hits_in      = hits_ff;
      status_in    = status_ff;
      clr_in       = clr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = h_ff;
      mul_b        = MIX_M;
      q_pop        = 1'b0;
      bstat        = '0;
      fil_we       = 1'b0;
      fil_waddr    = r_ff[FA_W-1:0];
      fil_wdata    = 1'b1;

      case (state_ff)
         // Zero the filter one bit per cycle after reset.
         B_CLEAR: begin
            bstat.clearing = 1'b1;
            fil_we         = 1'b1;
            fil_waddr      = clr_ff;
            fil_wdata      = 1'b0;
            clr_in         = clr_ff + FA_W'(1);
            if (clr_ff == FA_W'(MAX_FILTER_BITS - 1)) begin
               state_in = B_IDLE;
            end
         end
         // Take the next job from the queue.
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_dout;
               case (q_dout.kind)
                  JOB_HASH: begin
                     h_in     = SEED0 ^ 32'(q_dout.len);
                     rest_in  = LEN_W'(q_dout.len);
                     pos_in   = '0;
                     pass_in  = 1'b0;
                     state_in = B_NEXT;
                  end
                  JOB_NOCONFIG: begin
                     bstat.key_free = 1'b1;
                     status_in      = ST_NOCONFIG;
                     hits_in        = '0;
                     state_in       = B_DONE;
                  end
                  default: begin
                     bstat.key_free = 1'b1;
                     status_in      = ST_TOO_LONG;
                     hits_in        = '0;
                     state_in       = B_DONE;
                  end
               endcase
            end
         end
         // Start a four-byte block, a tail, or the final mix.
         B_NEXT: begin
            k_in  = '0;
            bc_in = '0;
            if (rest_ff == '0) begin
               state_in = B_F1;
            end else begin
               chunk_in = (rest_ff >= LEN_W'(4)) ? 3'd4 : 3'(rest_ff);
               state_in = B_RD;
            end
         end
         B_RD: begin
            state_in = B_CAP;
         end
         // Gather key bytes little-endian.
         B_CAP: begin
            k_in   = k_ff | (32'(buf_rdata) << {bc_ff, 3'b000});
            pos_in = pos_ff + KA_W'(1);
            bc_in  = bc_ff + 2'd1;
            if ({1'b0, bc_ff} + 3'd1 == chunk_ff) begin
               rest_in  = rest_ff - LEN_W'(chunk_ff);
               state_in = (chunk_ff == 3'd4) ? B_K1 : B_T1;
            end else begin
               state_in = B_RD;
            end
         end
         // Block mix: k *= m; k ^= k >> 24; k *= m; h *= m; h ^= k.
         B_K1: begin
            mul_a    = k_ff;
            p_in     = mul_full[31:0];
            state_in = B_K2;
         end
         B_K2: begin
            mul_a    = p_ff ^ (p_ff >> 24);
            p_in     = mul_full[31:0];
            state_in = B_H1;
         end
         B_H1: begin
            k_in     = p_ff;
            mul_a    = h_ff;
            p_in     = mul_full[31:0];
            state_in = B_H2;
         end
         B_H2: begin
            h_in     = p_ff ^ k_ff;
            state_in = B_NEXT;
         end
         // Tail bytes: h ^= tail; h *= m.
         B_T1: begin
            mul_a    = h_ff ^ k_ff;
            p_in     = mul_full[31:0];
            state_in = B_T2;
         end
         B_T2: begin
            h_in     = p_ff;
            state_in = B_F1;
         end
         // Final avalanche.
         B_F1: begin
            mul_a    = h_ff ^ (h_ff >> 13);
            p_in     = mul_full[31:0];
            state_in = B_F2;
         end
         B_F2: begin
            if (!pass_ff) begin
               a_in     = hfin;
               h_in     = hfin ^ len32;
               pass_in  = 1'b1;
               rest_in  = LEN_W'(job_ff.len);
               pos_in   = '0;
               state_in = B_NEXT;
            end else begin
               bstat.key_free = 1'b1;
               b_in           = hfin;
               x_in           = a_ff;
               xs_in          = a_ff;
               pi_in          = '0;
               hits_in        = '0;
               r_in           = '0;
               bit_in         = '0;
               if (nh == '0) begin
                  status_in = ST_PRESENT;
                  state_in  = B_DONE;
               end else begin
                  state_in = B_PDIV;
               end
            end
         end
         // Bit-serial remainder of the probe position by the filter size.
         B_PDIV: begin
            if (rem_t >= {1'b0, nb}) begin
               r_in = NB_W'(rem_t - {1'b0, nb});
            end else begin
               r_in = NB_W'(rem_t);
            end
            xs_in  = xs_ff << 1;
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) begin
               state_in = B_PRD;
            end
         end
         B_PRD: begin
            state_in = B_PCHK;
         end
         // Probe the bit; on add set it when clear.
         B_PCHK: begin
            hits_in = hits_nx;
            fil_we  = !fil_rdata && job_ff.add;
            pi_in   = pi_ff + HC_W'(1);
            x_in    = x_nx;
            xs_in   = x_nx;
            r_in    = '0;
            bit_in  = '0;
            if (pi_ff + HC_W'(1) == nh) begin
               status_in = (7'(hits_nx) == 7'(nh)) ? ST_PRESENT : ST_ABSENT;
               state_in  = B_DONE;
            end else begin
               state_in = B_PDIV;
            end
         end
         // Hand the result to the output register.
         B_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hits_ff, status_ff};
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      p_ff        <= p_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      xs_ff       <= xs_in;
      pass_ff     <= pass_in;
      pos_ff      <= pos_in;
      rest_ff     <= rest_in;
      bc_ff       <= bc_in;
      chunk_ff    <= chunk_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      pi_ff       <= pi_in;
      hits_ff     <= hits_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign buf_raddr  = pos_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Filter bit array.
   bfca_ram #(
      .WIDTH (1),
      .DEPTH (MAX_FILTER_BITS)
   ) u_filter (
      .clock   (clock),
      .wr_en   (fil_we),
      .wr_addr (fil_waddr),
      .wr_data (fil_wdata),
      .rd_addr (r_ff[FA_W-1:0]),
      .rd_data (fil_rdata)
   );

endmodule

>>> hw/rtl/bloom_filter_check_add.sv
// ----------------------------------------------------------------------------
// bloom_filter_check_add: bloom filter membership check and insert
// Keys arrive one byte per item; each finished key is hashed twice with
// MurmurHash2 and probed by double hashing in a filter bit array.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_     in         tdata = key_byte, tlast = last_byte, tuser = operation
//   rsp_     out        tdata[1:0] = status, tdata[7:2] = hit_count
//   csr_     in         index 0 = num_bits, index 1 = num_hashes
//
// Key bytes are taken one per cycle while the buffer is free, the queue has room
// and the filter is not being cleared; after the last byte the buffer is held while
// the key is hashed twice on the shared multiplier. A pass gathers and mixes each
// four-byte block, then gathers and mixes any tail and runs the final avalanche.
// Each probe runs the bit-serial remainder, then reads the filter. After reset the
// filter is cleared one bit per cycle with the input closed. A stalled result waits
// in the output register while the next key is taken in.
// ----------------------------------------------------------------------------
module bloom_filter_check_add
   import bfca_pkg::*;
#(
   parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
   parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
   parameter int MAX_HASHES      = DEF_MAX_HASHES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key_byte
   input  logic        req_tlast,
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // status [1:0], hit_count [7:2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int KA_W = $clog2(MAX_KEY_BYTES);

   logic [16:0]     num_bits_ff, num_bits_in;
   logic [5:0]      num_hashes_ff, num_hashes_in;
   back_stat_type   bstat;
   logic            q_full, q_empty, q_push, q_pop;
   job_type         q_din, q_dout;
   logic            buf_we;
   logic [KA_W-1:0] buf_waddr, buf_raddr;
   logic [7:0]      buf_wdata, buf_rdata;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      num_bits_in   = num_bits_ff;
      num_hashes_in = num_hashes_ff;
      if (csr_valid) begin
         if (csr_index == CSR_NUM_BITS) begin
            num_bits_in = csr_wdata[16:0];
         end else if (csr_index == CSR_NUM_HASHES) begin
            num_hashes_in = csr_wdata[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff   <= 17'd0;
         num_hashes_ff <= 6'd1;
      end else begin
         num_bits_ff   <= num_bits_in;
         num_hashes_ff <= num_hashes_in;
      end
   end

   bfca_front #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .num_bits   (num_bits_ff),
      .bstat      (bstat),
      .q_full     (q_full),
      .job_push   (q_push),
      .job        (q_din),
      .buf_we     (buf_we),
      .buf_waddr  (buf_waddr),
      .buf_wdata  (buf_wdata)
   );

   bfca_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   // Key byte buffer.
   bfca_ram #(
      .WIDTH (8),
      .DEPTH (MAX_KEY_BYTES)
   ) u_key_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   bfca_back #(
      .MAX_FILTER_BITS (MAX_FILTER_BITS),
      .MAX_KEY_BYTES   (MAX_KEY_BYTES),
      .MAX_HASHES      (MAX_HASHES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .num_bits   (num_bits_ff),
      .num_hashes (num_hashes_ff),
      .q_empty    (q_empty),
      .q_dout     (q_dout),
      .q_pop      (q_pop),
      .bstat      (bstat),
      .buf_raddr  (buf_raddr),
      .buf_rdata  (buf_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hw/rtl/bfca_checker.sv
// ----------------------------------------------------------------------------
// bfca_checker: port-level checks of the bloom filter block
// Watches reset behavior, the result register and result codes.
// ----------------------------------------------------------------------------
module bfca_checker
   import bfca_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Results without probing carry no hits.
   a_no_probe_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_NOCONFIG || rsp_tdata[1:0] == ST_TOO_LONG)
      |-> rsp_tdata[7:2] == 6'd0)
      else $error("hits reported without probing");

   // The filter clear keeps the input closed right after reset.
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input open during filter clear");

   // No result leaves right after reset.
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind bloom_filter_check_add bfca_checker u_chk (.*);

>>> test/bloom_filter_check_add_tb.sv
// ----------------------------------------------------------------------------
// bloom_filter_check_add_tb: self-checking bench for the bloom filter block
// Streams keys one byte per item under several filter sizes and probe
// counts. A scoreboard keeps its own filter, hashes each finished key and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module bloom_filter_check_add_tb;
   import bfca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILTER_SIZE = 65536;
   localparam int KEY_SIZE    = 64;
   localparam int PROBE_LIMIT = 32;

   typedef struct {
      status_type  status;
      logic [5:0]  hits;
   } lookup_result_type;

   // Scoreboard: predicts the lookup results and checks the block's output.
   class filter_scoreboard;
      bit                filter_map [FILTER_SIZE];
      logic [7:0]        key_bytes [KEY_SIZE];
      int unsigned       key_len;
      bit                key_overflow;
      logic [16:0]       num_bits;
      logic [5:0]        num_hashes;
      lookup_result_type pending_results [$];
      int                mismatches;

      function new();
         foreach (filter_map[i]) filter_map[i] = 1'b0;
         key_len = 0;
         key_overflow = 1'b0;
         num_bits = '0;
         num_hashes = 6'd1;
         mismatches = 0;
      endfunction

      function void set_register(logic [7:0] index, logic [31:0] value);
         if (index == CSR_NUM_BITS) num_bits = value[16:0];
         else if (index == CSR_NUM_HASHES) num_hashes = value[5:0];
      endfunction

      // Standard 32-bit MurmurHash2 over the buffered key.
      function logic [31:0] key_hash(logic [31:0] seed);
         logic [31:0] h, k;
         int unsigned pos, rest;
         h = seed ^ key_len;
         pos = 0;
         rest = key_len;
         while (rest >= 4) begin
            k = {key_bytes[pos+3], key_bytes[pos+2], key_bytes[pos+1], key_bytes[pos]};
            k = k * MIX_M;
            k = k ^ (k >> 24);
            k = k * MIX_M;
            h = h * MIX_M;
            h = h ^ k;
            pos += 4;
            rest -= 4;
         end
         if (rest == 3) h = h ^ ({24'd0, key_bytes[pos+2]} << 16);
         if (rest >= 2) h = h ^ ({24'd0, key_bytes[pos+1]} << 8);
         if (rest >= 1) begin
            h = h ^ {24'd0, key_bytes[pos]};
            h = h * MIX_M;
         end
         h = h ^ (h >> 13);
         h = h * MIX_M;
         h = h ^ (h >> 15);
         return h;
      endfunction

      // Notes one accepted item; a last byte yields one prediction.
      function void note_item(logic add, logic [7:0] kb, logic last);
         lookup_result_type r;
         logic [31:0] a, b, pos, nb;
         int unsigned nh;
         if (key_len < KEY_SIZE) begin
            key_bytes[key_len] = kb;
            key_len++;
         end else begin
            key_overflow = 1'b1;
         end
         if (!last) return;
         r.hits = '0;
         if (num_bits == 0) begin
            r.status = ST_NOCONFIG;
         end else if (key_overflow) begin
            r.status = ST_TOO_LONG;
         end else begin
            nb = (num_bits > FILTER_SIZE) ? FILTER_SIZE : num_bits;
            nh = (num_hashes > PROBE_LIMIT) ? PROBE_LIMIT : num_hashes;
            a = key_hash(SEED0);
            b = key_hash(a);
            for (int unsigned i = 0; i < nh; i++) begin
               pos = (a + i * b) % nb;
               if (filter_map[pos]) r.hits++;
               else if (add) filter_map[pos] = 1'b1;
            end
            r.status = (r.hits == nh) ? ST_PRESENT : ST_ABSENT;
         end
         key_len = 0;
         key_overflow = 1'b0;
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [7:0] data);
         lookup_result_type r;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result status %0d hits %0d",
                        data[1:0], data[7:2]);
            return;
         end
         r = pending_results.pop_front();
         if (data[1:0] !== r.status || data[7:2] !== r.hits) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result status %0d hits %0d, expected status %0d hits %0d",
                        data[1:0], data[7:2], r.status, r.hits);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   filter_scoreboard lookups = new();
   bit               idling_on = 1'b1;
   int               hold_off = 0;
   int               items_sent = 0;
   logic [7:0]       old_keys [$][$];

   bloom_filter_check_add dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= !(idling_on && $urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) lookups.check_result(rsp_tdata);
   end

   // Sends one key byte; req_tvalid stays high for a following item.
   task automatic send_item(logic op, logic [7:0] kb, logic last);
      @(negedge clock);
      if (idling_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= kb;
      req_tlast <= last;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      lookups.note_item(op, kb, last);
      items_sent++;
   endtask

   // Sends a whole key; the operation counts only on the last byte.
   task automatic send_key(logic [7:0] key_q[$], logic op);
      foreach (key_q[i]) begin
         if (i == key_q.size() - 1) send_item(op, key_q[i], 1'b1);
         else send_item(1'($urandom_range(1)), key_q[i], 1'b0);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lookups.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] index, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      lookups.set_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void random_key(output logic [7:0] key_q[$]);
      int unsigned len, pick;
      key_q = {};
      pick = $urandom_range(99);
      if (old_keys.size() > 0 && pick < 40) begin
         key_q = old_keys[$urandom_range(old_keys.size() - 1)];
         return;
      end
      if (pick < 90) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, KEY_SIZE);
      else len = $urandom_range(KEY_SIZE + 1, KEY_SIZE + 16);
      repeat (len) key_q.push_back(8'($urandom_range(255)));
      if (len <= KEY_SIZE) begin
         old_keys.push_back(key_q);
         if (old_keys.size() > 30) void'(old_keys.pop_front());
      end
   endfunction

   // Limit on the whole run.
   initial begin
      #10_000_000;
      $display("bloom_filter_check_add_tb failed");
      $finish;
   end

   initial begin
      logic [7:0]  key_q[$];
      logic [16:0] bits_pick [8] = '{1, 7, 64, 1000, 65535, 65536, 131071, 300};
      logic [5:0]  hash_pick [8] = '{0, 1, 2, 3, 5, 32, 63, 4};
      int phase;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: an unconfigured filter, then extremes and repeats.
      send_key('{8'h00}, 1'b1);
      drain();
      write_reg(CSR_NUM_BITS, 32'hffff_ffff);
      write_reg(CSR_NUM_HASHES, 32'd32);
      send_key('{8'hff}, 1'b1);
      send_key('{8'hff}, 1'b0);
      send_key('{8'h00, 8'hff}, 1'b0);
      send_key('{8'h01, 8'h02, 8'h03}, 1'b1);
      send_key('{8'h01, 8'h02, 8'h03, 8'h04}, 1'b1);
      send_key('{8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
      drain();
      // Zero probes counts as present; unknown registers are ignored.
      write_reg(CSR_NUM_HASHES, 32'd0);
      write_reg(8'd2, 32'd5);
      write_reg(8'hff, 32'h5555_aaaa);
      send_key('{8'haa, 8'h55, 8'h80, 8'h7f, 8'h10}, 1'b0);
      drain();
      write_reg(CSR_NUM_BITS, 32'd1);
      write_reg(CSR_NUM_HASHES, 32'd63);
      send_key('{8'h42}, 1'b0);
      send_key('{8'h42}, 1'b1);
      send_key('{8'h43, 8'h44}, 1'b0);
      drain();

      // Random phases, each under its own filter setting.
      phase = 0;
      while (items_sent < 1400) begin
         write_reg(CSR_NUM_BITS, (phase % 5 == 4) ? 32'd0 :
                   {15'($urandom_range(32'h7fff)), bits_pick[$urandom_range(7)]});
         write_reg(CSR_NUM_HASHES,
                   {26'($urandom), hash_pick[$urandom_range(99) < 25 ? $urandom_range(7) :
                                             $urandom_range(1, 3)]});
         idling_on = (phase != 2);
         if (phase == 3) hold_off = 600;
         repeat ($urandom_range(10, 30)) begin
            random_key(key_q);
            send_key(key_q, 1'($urandom_range(1)));
         end
         drain();
         phase++;
      end

      drain();
      repeat (200) @(posedge clock);
      lookups.mismatches += lookups.pending_results.size();
      if (lookups.mismatches == 0) $display("bloom_filter_check_add_tb passed");
      else $display("bloom_filter_check_add_tb failed");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/bfca_pkg.sv
hw/rtl/bfca_ram.sv
hw/rtl/bfca_queue.sv
hw/rtl/bfca_front.sv
hw/rtl/bfca_back.sv
hw/rtl/bloom_filter_check_add.sv
hw/rtl/bfca_checker.sv
test/bloom_filter_check_add_tb.sv
